// ----- hdl/tfa_pkg.sv -----
// Shared constants and helpers for the triangle facet attributes block.
// No dependencies; imported by the top level and the root/quotient step.
`timescale 1ns / 1ps

package tfa_pkg;

	localparam int COORD_WIDTH_DEF = 24;  // default vertex coordinate width, Q4.20
	localparam int NORM_W          = 16;  // normal component width, Q1.14
	localparam int NORM_STEPS      = 16;  // quotient bits resolved per normal component
	localparam int NORM_SHIFT      = 30;  // 2^30 = (2 * 2^14)^2 scale of the normal compare
	localparam int AREA_W          = 49;  // area width, Q9.40

	function automatic int max_int(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

endpackage

// ----- hdl/triangle_facet_attributes.sv -----
// Triangle facet attributes: centroid, unit normal and area of one triangle.
// Depends on tfa_pkg and tfa_isq_step.
`timescale 1ns / 1ps

// Usage
// - Input channel (in_valid/in_ready): one item is one triangle, vertices
//   A, B, C as signed Q4.20 coordinates.
// - Output channel (out_valid/out_ready): one item per triangle, in order:
//   centroid (Q4.20), unit normal of AB x AC (Q1.14, half away from zero)
//   and area (Q9.40, saturating). A zero-area triangle gives a zero normal,
//   zero area and degenerate = 1.
// - Throughput: one triangle per cycle. The whole pipeline advances on one
//   enable, so the rate is set by the output handshake alone.
// - Pipeline: five front stages (edges, products, cross, square partials,
//   squares), one stage for the squared length, one stage per bit of the
//   integer root (2 * COORD_WIDTH + 3 stages, the normal quotients are
//   resolved in the first 16 of them alongside), then the output register.
// - Stall: while out_valid is high and out_ready low, every stage holds and
//   in_ready is low; nothing is dropped or repeated.
// - Reset: arst_n clears all valid bits; no item is in flight afterwards.
//   Payload registers are not reset.
module triangle_facet_attributes #(
	parameter int COORD_WIDTH = tfa_pkg::COORD_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [COORD_WIDTH-1:0]       a_x,
	input  logic signed [COORD_WIDTH-1:0]       a_y,
	input  logic signed [COORD_WIDTH-1:0]       a_z,
	input  logic signed [COORD_WIDTH-1:0]       b_x,
	input  logic signed [COORD_WIDTH-1:0]       b_y,
	input  logic signed [COORD_WIDTH-1:0]       b_z,
	input  logic signed [COORD_WIDTH-1:0]       c_x,
	input  logic signed [COORD_WIDTH-1:0]       c_y,
	input  logic signed [COORD_WIDTH-1:0]       c_z,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [COORD_WIDTH-1:0]       centre_x,
	output logic signed [COORD_WIDTH-1:0]       centre_y,
	output logic signed [COORD_WIDTH-1:0]       centre_z,
	output logic signed [tfa_pkg::NORM_W-1:0]   normal_x,
	output logic signed [tfa_pkg::NORM_W-1:0]   normal_y,
	output logic signed [tfa_pkg::NORM_W-1:0]   normal_z,
	output logic        [tfa_pkg::AREA_W-1:0]   facet_area,
	output logic                                degenerate
);
	import tfa_pkg::*;

	localparam int CW   = COORD_WIDTH;
	localparam int DW   = CW + 1;            // edge vector component
	localparam int PW   = 2 * DW;            // cross product partial term
	localparam int MW   = 2 * CW + 2;        // cross component magnitude
	localparam int H    = MW / 2;            // split point for squaring
	localparam int MSQW = 2 * MW;            // squared magnitude
	localparam int SW   = MSQW + 2;          // squared length S
	localparam int RW   = SW / 2;            // isqrt(S)
	localparam int YW   = CW + 3;            // offset vertex sum
	localparam int RN   = YW + 2;            // reciprocal shift for divide by 3
	localparam int RPW  = YW + RN - 1;       // reciprocal product
	localparam int NS   = NORM_STEPS;
	localparam int NRW  = MSQW + NORM_SHIFT; // normal remainder
	localparam int NAW  = SW + NS;           // k * S
	localparam int HW   = max_int(RW, AREA_W);

	// sum + 1 + 3 * 2^(CW+1): non-negative, and the offset drops out of the
	// low CW bits of the quotient
	localparam logic [CW+3:0]  YOFF     = {1'b0, 2'b11, {CW{1'b0}}, 1'b1};
	localparam logic [RN-2:0]  RECIP3   = (RN - 1)'(((RN + 1)'(1) << RN) / 3);
	localparam logic [AREA_W-1:0] AREA_MAX = '1;

	logic adv;

	logic signed [CW-1:0] va [0:2];
	logic signed [CW-1:0] vb [0:2];
	logic signed [CW-1:0] vc [0:2];
	logic [CW+3:0]        ysum [0:2];

	// stage 1: edges and offset sums
	logic                 v_s1;
	logic signed [DW-1:0] ab_s1 [0:2];
	logic signed [DW-1:0] ac_s1 [0:2];
	logic [YW-1:0]        y_s1 [0:2];

	// stage 2: cross product terms, reciprocal products
	logic                 v_s2;
	logic signed [PW-1:0] pa_s2 [0:2];
	logic signed [PW-1:0] pb_s2 [0:2];
	logic [RPW-1:0]       rq_s2 [0:2];
	logic [YW-1:0]        y_s2 [0:2];

	// stage 3: cross magnitudes, centroid
	logic signed [PW:0]   cr [0:2];
	logic signed [PW:0]   cabs [0:2];
	logic [YW-1:0]        q0 [0:2];
	logic [YW-1:0]        r3 [0:2];
	logic [YW-1:0]        qc [0:2];
	logic                 v_s3;
	logic [MW-1:0]        mag_s3 [0:2];
	logic                 neg_s3 [0:2];
	logic [CW-1:0]        ctr_s3 [0:2];

	// stage 4: square partial products
	logic                 v_s4;
	logic [2*H-1:0]       hh_s4 [0:2];
	logic [2*H-1:0]       hl_s4 [0:2];
	logic [2*H-1:0]       ll_s4 [0:2];
	logic                 neg_s4 [0:2];
	logic [CW-1:0]        ctr_s4 [0:2];

	// stage 5: squared magnitudes
	logic                 v_s5;
	logic [MSQW-1:0]      msq_s5 [0:2];
	logic                 neg_s5 [0:2];
	logic [CW-1:0]        ctr_s5 [0:2];
	logic [SW-1:0]        ssum;

	// root / quotient pipeline, element 0 holds S
	logic                 v_p    [0:RW];
	logic [SW-1:0]        rt_rem_p [0:RW];
	logic [RW-1:0]        rt_acc_p [0:RW];
	logic [SW-1:0]        rt_rem_n [0:RW-1];
	logic [RW-1:0]        rt_acc_n [0:RW-1];
	logic                 rt_take  [0:RW-1];
	logic                 deg_p  [0:RW];
	logic                 neg_p  [0:RW][0:2];
	logic [CW-1:0]        ctr_p  [0:RW][0:2];
	logic [NS-1:0]        k_p    [0:RW][0:2];
	logic [SW-1:0]        base_p [0:NS];
	logic [NRW-1:0]       nr_rem_p [0:NS][0:2];
	logic [NAW-1:0]       nr_acc_p [0:NS][0:2];
	logic [NRW-1:0]       nr_rem_n [0:NS-1][0:2];
	logic [NAW-1:0]       nr_acc_n [0:NS-1][0:2];
	logic                 nr_take  [0:NS-1][0:2];

	// output
	logic [RW:0]              r1;
	logic [HW-1:0]            hx;
	logic [AREA_W-1:0]        area_c;
	logic [NS:0]              kr [0:2];
	logic signed [NORM_W-1:0] nrm_c [0:2];
	logic                     out_v_q;
	logic [CW-1:0]            ctr_q [0:2];
	logic [NORM_W-1:0]        nrm_q [0:2];
	logic [AREA_W-1:0]        area_q;
	logic                     deg_q;

	// one enable for the whole pipeline; the output register is the last stage
	assign adv      = !out_v_q || out_ready;
	assign in_ready = adv;

	always_comb begin
		va[0] = a_x; va[1] = a_y; va[2] = a_z;
		vb[0] = b_x; vb[1] = b_y; vb[2] = b_z;
		vc[0] = c_x; vc[1] = c_y; vc[2] = c_z;
		for (int c = 0; c < 3; c++) begin
			ysum[c] = (CW + 4)'(va[c]) + (CW + 4)'(vb[c]) + (CW + 4)'(vc[c]) + YOFF;
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			cr[c]   = (PW + 1)'(pa_s2[c]) - (PW + 1)'(pb_s2[c]);
			cabs[c] = cr[c][PW] ? -cr[c] : cr[c];
			// floor(y / 3): reciprocal estimate is exact or one low
			q0[c]   = YW'(rq_s2[c][RPW-1:RN]);
			r3[c]   = y_s2[c] - (q0[c] << 1) - q0[c];
			qc[c]   = (r3[c] >= YW'(3)) ? (q0[c] + YW'(1)) : q0[c];
		end
		ssum = SW'(msq_s5[0]) + SW'(msq_s5[1]) + SW'(msq_s5[2]);
	end

	// front stages
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				ab_s1[c] <= DW'(vb[c]) - DW'(va[c]);
				ac_s1[c] <= DW'(vc[c]) - DW'(va[c]);
				y_s1[c]  <= ysum[c][YW-1:0];

				rq_s2[c] <= RPW'(y_s1[c]) * RPW'(RECIP3);
				y_s2[c]  <= y_s1[c];

				mag_s3[c] <= cabs[c][MW-1:0];
				neg_s3[c] <= cr[c][PW];
				ctr_s3[c] <= qc[c][CW-1:0];

				hh_s4[c]  <= (2 * H)'(mag_s3[c][MW-1:H]) * (2 * H)'(mag_s3[c][MW-1:H]);
				hl_s4[c]  <= (2 * H)'(mag_s3[c][MW-1:H]) * (2 * H)'(mag_s3[c][H-1:0]);
				ll_s4[c]  <= (2 * H)'(mag_s3[c][H-1:0]) * (2 * H)'(mag_s3[c][H-1:0]);
				neg_s4[c] <= neg_s3[c];
				ctr_s4[c] <= ctr_s3[c];

				msq_s5[c] <= (MSQW'(hh_s4[c]) << (2 * H)) + (MSQW'(hl_s4[c]) << (H + 1))
					+ MSQW'(ll_s4[c]);
				neg_s5[c] <= neg_s4[c];
				ctr_s5[c] <= ctr_s4[c];
			end
			// c_k = ab[k+1] * ac[k+2] - ab[k+2] * ac[k+1]
			pa_s2[0] <= PW'(ab_s1[1]) * PW'(ac_s1[2]);
			pb_s2[0] <= PW'(ab_s1[2]) * PW'(ac_s1[1]);
			pa_s2[1] <= PW'(ab_s1[2]) * PW'(ac_s1[0]);
			pb_s2[1] <= PW'(ab_s1[0]) * PW'(ac_s1[2]);
			pa_s2[2] <= PW'(ab_s1[0]) * PW'(ac_s1[1]);
			pb_s2[2] <= PW'(ab_s1[1]) * PW'(ac_s1[0]);
		end
	end

	// bit-per-stage units: integer root of S, and per component the largest
	// k with k^2 * S <= 2^30 * m^2 (k = floor(2^15 * m / |c|))
	for (genvar i = 0; i < RW; i++) begin : g_root
		tfa_isq_step #(.WR(SW), .WA(RW), .WB(1), .J(RW - 1 - i)) u_root (
			.rem   (rt_rem_p[i]),
			.acc   (rt_acc_p[i]),
			.base  (1'b1),
			.rem_n (rt_rem_n[i]),
			.acc_n (rt_acc_n[i]),
			.take  (rt_take[i])
		);
	end

	for (genvar i = 0; i < NS; i++) begin : g_norm
		for (genvar c = 0; c < 3; c++) begin : g_lane
			tfa_isq_step #(.WR(NRW), .WA(NAW), .WB(SW), .J(NS - 1 - i)) u_quo (
				.rem   (nr_rem_p[i][c]),
				.acc   (nr_acc_p[i][c]),
				.base  (base_p[i]),
				.rem_n (nr_rem_n[i][c]),
				.acc_n (nr_acc_n[i][c]),
				.take  (nr_take[i][c])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rt_rem_p[0] <= ssum;
			rt_acc_p[0] <= '0;
			base_p[0]   <= ssum;
			deg_p[0]    <= (ssum == '0);
			for (int c = 0; c < 3; c++) begin
				nr_rem_p[0][c] <= NRW'(msq_s5[c]) << NORM_SHIFT;
				nr_acc_p[0][c] <= '0;
				k_p[0][c]      <= '0;
				neg_p[0][c]    <= neg_s5[c];
				ctr_p[0][c]    <= ctr_s5[c];
			end
			for (int i = 0; i < RW; i++) begin
				rt_rem_p[i+1] <= rt_rem_n[i];
				rt_acc_p[i+1] <= rt_take[i] ? rt_acc_n[i] : rt_acc_p[i];
				deg_p[i+1]    <= deg_p[i];
				for (int c = 0; c < 3; c++) begin
					neg_p[i+1][c] <= neg_p[i][c];
					ctr_p[i+1][c] <= ctr_p[i][c];
				end
			end
			for (int i = 0; i < NS; i++) begin
				base_p[i+1] <= base_p[i];
				for (int c = 0; c < 3; c++) begin
					nr_rem_p[i+1][c] <= nr_rem_n[i][c];
					nr_acc_p[i+1][c] <= nr_acc_n[i][c];
					k_p[i+1][c]      <= k_p[i][c] | (NS'(nr_take[i][c]) << (NS - 1 - i));
				end
			end
			for (int i = NS; i < RW; i++) begin
				for (int c = 0; c < 3; c++) begin
					k_p[i+1][c] <= k_p[i][c];
				end
			end
		end
	end

	// final rounding: area = (isqrt(S) + 1) / 2 saturated, normal = (k + 1) / 2
	always_comb begin
		r1     = (RW + 1)'(rt_acc_p[RW]) + (RW + 1)'(1);
		hx     = HW'(r1[RW:1]);
		area_c = (hx > HW'(AREA_MAX)) ? AREA_MAX : hx[AREA_W-1:0];
		for (int c = 0; c < 3; c++) begin
			kr[c]    = (NS + 1)'(k_p[RW][c]) + (NS + 1)'(1);
			nrm_c[c] = NORM_W'(kr[c][NS:1]);
			if (neg_p[RW][c]) begin
				nrm_c[c] = -nrm_c[c];
			end
			if (deg_p[RW]) begin
				nrm_c[c] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			area_q <= area_c;
			deg_q  <= deg_p[RW];
			for (int c = 0; c < 3; c++) begin
				ctr_q[c] <= ctr_p[RW][c];
				nrm_q[c] <= nrm_c[c];
			end
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			for (int i = 0; i <= RW; i++) begin
				v_p[i] <= 1'b0;
			end
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s1   <= in_valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			v_p[0] <= v_s5;
			for (int i = 0; i < RW; i++) begin
				v_p[i+1] <= v_p[i];
			end
			out_v_q <= v_p[RW];
		end
	end

	assign out_valid  = out_v_q;
	assign centre_x   = ctr_q[0];
	assign centre_y   = ctr_q[1];
	assign centre_z   = ctr_q[2];
	assign normal_x   = nrm_q[0];
	assign normal_y   = nrm_q[1];
	assign normal_z   = nrm_q[2];
	assign facet_area = area_q;
	assign degenerate = deg_q;

endmodule

// ----- hdl/tfa_isq_step.sv -----
// One bit of a restoring square-root style search: tests whether setting
// bit J of the running quotient keeps the remainder non-negative.
// Depends on tfa_pkg.
`timescale 1ns / 1ps

module tfa_isq_step #(
	parameter int WR = 8,   // remainder width
	parameter int WA = 8,   // accumulator width (quotient times base)
	parameter int WB = 1,   // base width
	parameter int J  = 0    // bit position tested
) (
	input  logic [WR-1:0] rem,
	input  logic [WA-1:0] acc,
	input  logic [WB-1:0] base,
	output logic [WR-1:0] rem_n,
	output logic [WA-1:0] acc_n,
	output logic          take
);
	import tfa_pkg::*;

	localparam int WT = max_int(max_int(WA + J + 1, WB + 2 * J), WR) + 1;

	logic [WT-1:0] trial;

	// (k + 2^J)^2 * base - k^2 * base = 2^(J+1) * acc + 2^(2J) * base
	assign trial = (WT'(acc) << (J + 1)) + (WT'(base) << (2 * J));
	assign take  = (trial <= WT'(rem));
	assign rem_n = take ? (rem - trial[WR-1:0]) : rem;
	assign acc_n = take ? (acc + (WA'(base) << J)) : acc;

endmodule
